FILE: hdl/pfa_pkg.sv
// Package for the bitmap page frame allocator.
// Sizes, action and status codes, sequencer states and word-unit modes.
// No dependencies.
package pfa_pkg;

  localparam int MAX_FRAMES = 8192;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_BITS  = 32;
  localparam int WORDS      = MAX_FRAMES / WORD_BITS;
  localparam int WW         = $clog2(WORDS);           // bitmap row address
  localparam int FCW        = $clog2(MAX_FRAMES + 1);  // frame count / bound
  localparam int WPW        = FCW - 5;                 // word pointer incl. bound
  localparam int IDXW       = 32 - PAGE_SHIFT;         // frame index of an address
  localparam int CFGW       = 14;                      // frame_count register
  localparam int PAGESW     = IDXW + 1;                // clipped page count

  localparam logic [CFGW-1:0] FC_RESET      = 14'd8192;
  localparam logic [31:0]     RESERVED_TYPE = 32'd2;
  localparam logic [31:0]     NO_FRAME      = 32'hFFFF_FFFF;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_MARK    = 2'd1;
  localparam logic [1:0] ACT_FREE    = 2'd2;
  localparam logic [1:0] ACT_RESERVE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FRAME = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic REG_FRAME_COUNT = 1'b0;

  typedef enum logic [1:0] {
    MODE_SET,
    MODE_CLR,
    MODE_FIND
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_RANGE,
    S_READ,
    S_EVAL
  } state_t;

  typedef struct packed {
    logic [FCW-1:0] lo;
    logic [FCW-1:0] hi;
    mode_t          mode;
  } span_t;

endpackage

FILE: hdl/bitmap_page_frame_allocator_top.sv
// Bitmap page frame allocator: frame_count register on the APB port, sequencer below.
// A range error, no-op or zero count ends at the range check; otherwise the
// sequencer visits bitmap rows (up to 256 rows), reading each row and then
// writing it back through the word unit and the bitmap memory. One item at a time.
// Reset clears the bitmap at once (row valid bits) and sets frame_count to 8192.
// Results show for one cycle on done; the receiver cannot stall. Depends on pfa_pkg, pfa_seq.
module bitmap_page_frame_allocator_top
  import pfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] address,
  input  logic [31:0] length,
  input  logic [31:0] region_type,
  output logic        done,
  output logic [31:0] frame_address,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFGW-1:0] frame_count;
  logic [FCW-1:0]  count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FC_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_COUNT) begin
      frame_count <= pwdata[CFGW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_FRAME_COUNT) ? 32'(frame_count) : '0;

  assign count = (32'(frame_count) > 32'(MAX_FRAMES)) ? FCW'(MAX_FRAMES) : FCW'(frame_count);

  pfa_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .count         (count),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .address       (address),
    .length        (length),
    .region_type   (region_type),
    .done          (done),
    .frame_address (frame_address),
    .status        (status)
  );

endmodule

FILE: hdl/pfa_bitmap_mem.sv
// Used-bit memory: one 32-bit row per 32 frames, registered read.
// Row valid bits cleared by reset make unwritten rows read as all free.
// Depends on pfa_pkg.
module pfa_bitmap_mem
  import pfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [WW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [WW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]     row_valid;
  logic [WORD_BITS-1:0] rd_word;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

FILE: hdl/pfa_word_unit.sv
// Shared word unit: masks one bitmap row to a frame span, then sets,
// clears, or finds and sets the lowest free frame in it.
// Depends on pfa_pkg.
module pfa_word_unit
  import pfa_pkg::*;
(
  input  span_t                span,
  input  logic [WPW-1:0]       word_idx,
  input  logic [WORD_BITS-1:0] data,
  output logic [WORD_BITS-1:0] new_data,
  output logic                 found,
  output logic [4:0]           pos
);

  logic [WPW-1:0]       lo_w;
  logic [WPW-1:0]       hi_w;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] span_mask;
  logic [WORD_BITS-1:0] cand;

  assign lo_w = span.lo[FCW-1:5];
  assign hi_w = span.hi[FCW-1:5];

  always_comb begin
    if (word_idx > lo_w) begin
      lo_mask = '1;
    end else if (word_idx == lo_w) begin
      lo_mask = '1 << span.lo[4:0];
    end else begin
      lo_mask = '0;
    end
    if (word_idx < hi_w) begin
      hi_mask = '1;
    end else if (word_idx == hi_w) begin
      hi_mask = (32'd1 << span.hi[4:0]) - 32'd1;
    end else begin
      hi_mask = '0;
    end
    span_mask = lo_mask & hi_mask;
  end

  assign cand  = ~data & span_mask;
  assign found = |cand;

  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (cand[b]) begin
        pos = 5'(b);
      end
    end
  end

  always_comb begin
    case (span.mode)
      MODE_SET:  new_data = data | span_mask;
      MODE_CLR:  new_data = data & ~span_mask;
      MODE_FIND: new_data = data | (32'd1 << pos);
      default:   new_data = data;
    endcase
  end

endmodule

FILE: hdl/pfa_seq.sv
// Sequencer: turns each action into a frame span, walks its bitmap rows
// through the word unit, reading then writing back each row, and issues the result.
// Depends on pfa_pkg, pfa_bitmap_mem, pfa_word_unit.
module pfa_seq
  import pfa_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic [FCW-1:0] count,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     action,
  input  logic [31:0]    address,
  input  logic [31:0]    length,
  input  logic [31:0]    region_type,
  output logic           done,
  output logic [31:0]    frame_address,
  output logic [1:0]     status
);

  state_t state, state_next;

  logic [1:0]        act;
  logic [31:0]       addr;
  logic [31:0]       len;
  logic [31:0]       rtype;
  logic [PAGESW-1:0] pages_cl, pages_cl_next;
  span_t             span, span_next;
  logic [WPW-1:0]    w, w_next;
  logic [WPW-1:0]    w_last, w_last_next;

  logic              fin;
  logic [31:0]       fin_addr;
  logic [1:0]        fin_status;

  logic [IDXW-1:0]   idx;
  logic [PAGESW-1:0] pages;
  logic [PAGESW-1:0] room;
  logic [PAGESW:0]   span_end;
  logic [PAGESW:0]   end_cl;

  logic              rd_en;
  logic              wr_en;
  logic [31:0]       rd_data;
  logic [31:0]       new_data;
  logic              found;
  logic [4:0]        pos;

  assign idx  = addr[31:PAGE_SHIFT];
  assign busy = (state != S_IDLE);

  pfa_bitmap_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (w[WW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (w[WW-1:0]),
    .wr_data (new_data)
  );

  pfa_word_unit u_unit (
    .span     (span),
    .word_idx (w),
    .data     (rd_data),
    .new_data (new_data),
    .found    (found),
    .pos      (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act   <= action;
      addr  <= address;
      len   <= length;
      rtype <= region_type;
    end
    pages_cl <= pages_cl_next;
    span     <= span_next;
    w        <= w_next;
    w_last   <= w_last_next;
    if (fin) begin
      frame_address <= fin_addr;
      status        <= fin_status;
    end
  end

  always_comb begin
    pages    = PAGESW'(({1'b0, len} + 33'd4095) >> PAGE_SHIFT);
    room     = {1'b0, ~addr[31:PAGE_SHIFT]} + PAGESW'(1);
    span_end = {1'b0, 1'b0, idx} + {1'b0, pages_cl};
    end_cl   = (span_end > (PAGESW + 1)'(count)) ? (PAGESW + 1)'(count) : span_end;
  end

  always_comb begin
    state_next    = state;
    pages_cl_next = pages_cl;
    span_next     = span;
    w_next        = w;
    w_last_next   = w_last;
    fin           = 1'b0;
    fin_addr      = '0;
    fin_status    = ST_OK;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        pages_cl_next = (pages > room) ? room : pages;
        state_next    = S_RANGE;
      end
      S_RANGE: begin
        state_next = S_READ;
        case (act)
          ACT_ALLOC: begin
            span_next.lo   = '0;
            span_next.hi   = count;
            span_next.mode = MODE_FIND;
            if (count == '0) begin
              fin        = 1'b1;
              fin_addr   = NO_FRAME;
              fin_status = ST_NO_FRAME;
              state_next = S_IDLE;
            end
          end
          ACT_MARK, ACT_FREE: begin
            span_next.lo   = FCW'(idx);
            span_next.hi   = FCW'(idx) + FCW'(1);
            span_next.mode = (act == ACT_MARK) ? MODE_SET : MODE_CLR;
            if (idx >= IDXW'(count)) begin
              fin        = 1'b1;
              fin_status = ST_RANGE;
              state_next = S_IDLE;
            end
          end
          ACT_RESERVE: begin
            span_next.lo   = FCW'(idx);
            span_next.hi   = FCW'(end_cl);
            span_next.mode = MODE_SET;
            if (rtype != RESERVED_TYPE || (PAGESW + 1)'(idx) >= end_cl) begin
              fin        = 1'b1;
              state_next = S_IDLE;
            end
          end
          default: begin
            fin        = 1'b1;
            state_next = S_IDLE;
          end
        endcase
        w_next      = span_next.lo[FCW-1:5];
        w_last_next = WPW'((span_next.hi - FCW'(1)) >> 5);
      end
      S_READ: begin
        rd_en      = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        wr_en = (span.mode != MODE_FIND) || found;
        if (span.mode == MODE_FIND && found) begin
          fin        = 1'b1;
          fin_addr   = 32'({w[WW-1:0], pos}) << PAGE_SHIFT;
          state_next = S_IDLE;
        end else if (w == w_last) begin
          fin        = 1'b1;
          if (span.mode == MODE_FIND) begin
            fin_addr   = NO_FRAME;
            fin_status = ST_NO_FRAME;
          end
          state_next = S_IDLE;
        end else begin
          w_next     = w + WPW'(1);
          state_next = S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
